// File: hw/rtl/sra_pkg.sv
// shared constants, codes and helpers for the scaled region alpha blitter
`default_nettype none
package sra_pkg;

  localparam int CANVAS_WORDS = 65536;
  localparam int IMAGE_WORDS  = 16384;
  localparam int CANVAS_AW    = (CANVAS_WORDS > 1) ? $clog2(CANVAS_WORDS) : 1;
  localparam int IMAGE_AW     = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;

  // word index widths wide enough for any computed index
  localparam int CIDX_W = 25;
  localparam int SIDX_W = 26;

  localparam logic [CIDX_W-1:0] CANVAS_LIMIT = CIDX_W'(CANVAS_WORDS);
  localparam logic [SIDX_W-1:0] IMAGE_LIMIT  = SIDX_W'(IMAGE_WORDS);

  localparam int DIV_NW = 24;
  localparam int DIV_DW = 12;

  typedef enum logic [1:0] {
    ACT_LOAD_IMAGE  = 2'd0,
    ACT_LOAD_CANVAS = 2'd1,
    ACT_READ_CANVAS = 2'd2,
    ACT_DRAW        = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_CANVAS_PITCH  = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_IMAGE_HEIGHT  = 3'd4
  } cfg_reg_t;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

  // exact floor(v / 255) for v up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sra_ram.sv
// simple dual port ram with registered read data
`default_nettype none
module sra_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/sra_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module sra_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sra_pkg::DIV_NW-1:0] num,
  input  wire logic [sra_pkg::DIV_DW-1:0] den,
  output logic                           done,
  output logic      [sra_pkg::DIV_NW-1:0] quo,
  output logic      [sra_pkg::DIV_DW-1:0] rem
);
  import sra_pkg::*;

  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt, den_r;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial;
  logic              ge;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
    quo_nxt = {quo_r[DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(DIV_NW - 1);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: hw/rtl/sra_blend.sv
// source-over blend: products registered, divide by 255 after
`default_nettype none
module sra_blend (
  input  wire logic        clk,
  input  wire logic [31:0] src,
  input  wire logic [31:0] dst,
  output logic      [31:0] res
);
  import sra_pkg::*;

  logic [15:0] ps_r [3];
  logic [15:0] pd_r [3];
  logic [31:0] src_r, dst_r;
  logic [7:0]  alpha;
  logic [7:0]  inv;
  logic [7:0]  ch [3];

  assign alpha = src[31:24];
  assign inv   = ALPHA_OPAQUE - alpha;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ps_r[i] <= 16'(src[8*i +: 8]) * 16'(alpha);
      pd_r[i] <= 16'(dst[8*i +: 8]) * 16'(inv);
    end
    src_r <= src;
    dst_r <= dst;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch[i] = div255(ps_r[i] + pd_r[i]);
    end
    if (src_r[31:24] == ALPHA_OPAQUE) begin
      res = src_r;
    end else if (src_r[31:24] == ALPHA_CLEAR) begin
      res = dst_r;
    end else begin
      res = {ALPHA_OPAQUE, ch[2], ch[1], ch[0]};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scaled_region_alpha_blit.sv
// scaled region alpha blitter top level: command sequencer and stores
// Usage:
//   in_*  : command beats. in_tuser holds the action; load image pixel, load
//           canvas pixel, read canvas pixel or draw. in_tdata holds the
//           address, pixel and rectangle fields.
//   out_* : exactly one result beat per command, read data in out_tdata,
//           draw status in out_tuser (1 = rejected or nothing visible).
//   cfg_* : register writes, taken in the cycle cfg_we is high; the user must write only while idle, not enforced.
// Loads write their store when taken; reads wait in ST_RD_WAIT for the registered canvas ram read.
// A draw runs ST_CHECK, then 4 divisions in the shared divider setting up
// the scaling steps, then per row ST_ROW_START and ST_ROW_MUL, and per covered
// pixel ST_PIX_RD, ST_PIX_MUL and ST_PIX_WR (ram read, blend multiply, write back).
// Commands are taken one at a time, only while idle and only when the result
// slot is empty or the previous result leaves in the same cycle.
// Reset clears the control state and loads the register defaults; the
// canvas and image stores hold no defined contents until written.
// When out_tready stays low the result holds and no new command is taken.
`default_nettype none
module scaled_region_alpha_blit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // address[15:0], pixel_value[47:16], src_x[60:48], src_y[73:61],
  // src_w[85:74], src_h[97:86], dst_x[110:98], dst_y[123:111],
  // dst_w[135:124], dst_h[147:136], zero fill[151:148]
  input  wire logic [151:0] in_tdata,
  // action[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // read_data[31:0]
  output logic      [31:0]  out_tdata,
  // status[0]
  output logic              out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [11:0]  cfg_wdata
);
  import sra_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_CHECK, ST_DIV_X0, ST_DIV_XS, ST_DIV_Y0, ST_DIV_YS,
    ST_ROW_START, ST_ROW_MUL, ST_PIX_RD, ST_PIX_MUL, ST_PIX_WR
  } state_t;

  state_t state_r;

  logic [11:0] cw_r, ch_r, pitch_r, iw_r, ih_r;

  // input fields
  logic [15:0] f_addr;
  logic [31:0] f_pix;
  logic [1:0]  f_act;
  assign f_addr = in_tdata[15:0];
  assign f_pix  = in_tdata[47:16];
  assign f_act  = in_tuser;

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  logic [CIDX_W-1:0] addr_ext;
  logic              addr_c_ok, addr_i_ok;
  assign addr_ext  = CIDX_W'(f_addr);
  assign addr_c_ok = addr_ext < CANVAS_LIMIT;
  assign addr_i_ok = SIDX_W'(f_addr) < IMAGE_LIMIT;

  // draw command registers
  logic signed [12:0] sx_r, sy_r, dx_r, dy_r;
  logic [11:0]        sw_r, sh_r, dw_r, dh_r;
  logic               rd_ok_r;

  // clipping and checks
  logic signed [13:0] sx_end, sy_end, right_s, bottom_s, left_s, top_s;
  logic signed [13:0] ox0_s, oy0_s;
  logic               reject;
  always_comb begin
    sx_end   = 14'(sx_r) + $signed({2'b00, sw_r});
    sy_end   = 14'(sy_r) + $signed({2'b00, sh_r});
    left_s   = (dx_r < 0) ? 14'sd0 : 14'(dx_r);
    top_s    = (dy_r < 0) ? 14'sd0 : 14'(dy_r);
    right_s  = 14'(dx_r) + $signed({2'b00, dw_r});
    bottom_s = 14'(dy_r) + $signed({2'b00, dh_r});
    if (right_s > $signed({2'b00, cw_r})) right_s = $signed({2'b00, cw_r});
    if (bottom_s > $signed({2'b00, ch_r})) bottom_s = $signed({2'b00, ch_r});
    ox0_s    = left_s - 14'(dx_r);
    oy0_s    = top_s - 14'(dy_r);
    reject   = (sw_r == '0) || (sh_r == '0) || (dw_r == '0) || (dh_r == '0) ||
               (sx_r < 0) || (sy_r < 0) ||
               (sx_end > $signed({2'b00, iw_r})) ||
               (sy_end > $signed({2'b00, ih_r})) ||
               (left_s >= right_s) || (top_s >= bottom_s);
  end

  logic [11:0] left_r, right_r, bottom_r, x_r, y_r;
  logic [DIV_NW-1:0] px_r, py_r;
  logic [25:0] qx0_r, qx_r, qsx_r, qy_r, qsy_r;
  logic [11:0] rx0_r, remx_r, rsx_r, remy_r, rsy_r;
  logic [12:0] ry_r;
  logic [24:0] rbs_r;
  logic [23:0] rbc_r;

  // divider
  logic              div_start_r, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den, div_rem;
  always_comb begin
    case (state_r)
      ST_DIV_X0: begin div_num = px_r;           div_den = dw_r; end
      ST_DIV_XS: begin div_num = DIV_NW'(sw_r);  div_den = dw_r; end
      ST_DIV_Y0: begin div_num = py_r;           div_den = dh_r; end
      default:   begin div_num = DIV_NW'(sh_r);  div_den = dh_r; end
    endcase
  end

  sra_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  // nearest neighbor source position, capped at the last source pixel
  logic [11:0] capx, capy;
  logic [12:0] rx;
  logic [SIDX_W-1:0] sidx;
  logic [CIDX_W-1:0] cidx;
  always_comb begin
    capx = (qx_r >= 26'(sw_r)) ? sw_r - 12'd1 : qx_r[11:0];
    capy = (qy_r >= 26'(sh_r)) ? sh_r - 12'd1 : qy_r[11:0];
    rx   = 13'(sx_r[11:0]) + 13'(capx);
    sidx = SIDX_W'(rbs_r) + SIDX_W'(rx);
    cidx = CIDX_W'(rbc_r) + CIDX_W'(x_r);
  end

  // dda step for the next column and row
  logic [12:0] remx_sum, remy_sum;
  logic        remx_wrap, remy_wrap;
  assign remx_sum  = 13'(remx_r) + 13'(rsx_r);
  assign remy_sum  = 13'(remy_r) + 13'(rsy_r);
  assign remx_wrap = remx_sum >= 13'(dw_r);
  assign remy_wrap = remy_sum >= 13'(dh_r);

  // stores
  logic                 c_we, i_we;
  logic [CANVAS_AW-1:0] c_waddr, c_raddr, cw_addr_r;
  logic [IMAGE_AW-1:0]  i_raddr;
  logic [31:0]          c_wdata, c_rdata, i_rdata, blend_res;
  logic                 skip_r;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = addr_ext[CANVAS_AW-1:0];
    c_wdata = f_pix;
    c_raddr = addr_ext[CANVAS_AW-1:0];
    if (state_r == ST_PIX_WR) begin
      c_we    = !skip_r;
      c_waddr = cw_addr_r;
      c_wdata = blend_res;
    end else if (in_acc && (f_act == ACT_LOAD_CANVAS)) begin
      c_we = addr_c_ok;
    end
    if (state_r == ST_PIX_RD) begin
      c_raddr = cidx[CANVAS_AW-1:0];
    end
    i_we    = in_acc && (f_act == ACT_LOAD_IMAGE) && addr_i_ok;
    i_raddr = sidx[IMAGE_AW-1:0];
  end

  sra_ram #(.DEPTH(CANVAS_WORDS), .WIDTH(32)) u_canvas (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  sra_ram #(.DEPTH(IMAGE_WORDS), .WIDTH(32)) u_image (
    .clk(clk), .we(i_we), .waddr(f_addr[IMAGE_AW-1:0]), .wdata(f_pix),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  sra_blend u_blend (.clk(clk), .src(i_rdata), .dst(c_rdata), .res(blend_res));

  logic        out_valid_r, out_status_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      cw_r        <= 12'd256;
      ch_r        <= 12'd256;
      pitch_r     <= 12'd256;
      iw_r        <= 12'd128;
      ih_r        <= 12'd128;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_CANVAS_WIDTH:  cw_r    <= cfg_wdata;
          REG_CANVAS_HEIGHT: ch_r    <= cfg_wdata;
          REG_CANVAS_PITCH:  pitch_r <= cfg_wdata;
          REG_IMAGE_WIDTH:   iw_r    <= cfg_wdata;
          REG_IMAGE_HEIGHT:  ih_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && !in_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            out_data_r   <= '0;
            out_status_r <= 1'b0;
            rd_ok_r      <= addr_c_ok;
            sx_r <= $signed(in_tdata[60:48]);
            sy_r <= $signed(in_tdata[73:61]);
            sw_r <= in_tdata[85:74];
            sh_r <= in_tdata[97:86];
            dx_r <= $signed(in_tdata[110:98]);
            dy_r <= $signed(in_tdata[123:111]);
            dw_r <= in_tdata[135:124];
            dh_r <= in_tdata[147:136];
            case (f_act)
              ACT_READ_CANVAS: begin
                out_valid_r <= 1'b0;
                state_r     <= ST_RD_WAIT;
              end
              ACT_DRAW: begin
                out_valid_r <= 1'b0;
                state_r     <= ST_CHECK;
              end
              default:         out_valid_r <= 1'b1;
            endcase
          end
        end
        ST_RD_WAIT: begin
          out_data_r  <= rd_ok_r ? c_rdata : '0;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_CHECK: begin
          if (reject) begin
            out_status_r <= 1'b1;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end else begin
            left_r      <= left_s[11:0];
            right_r     <= right_s[11:0];
            y_r         <= top_s[11:0];
            bottom_r    <= bottom_s[11:0];
            px_r        <= DIV_NW'(ox0_s[12:0] * sw_r);
            py_r        <= DIV_NW'(oy0_s[12:0] * sh_r);
            div_start_r <= 1'b1;
            state_r     <= ST_DIV_X0;
          end
        end
        ST_DIV_X0: begin
          if (div_done) begin
            qx0_r <= 26'(div_quo); rx0_r <= div_rem;
            div_start_r <= 1'b1; state_r <= ST_DIV_XS;
          end
        end
        ST_DIV_XS: begin
          if (div_done) begin
            qsx_r <= 26'(div_quo); rsx_r <= div_rem;
            div_start_r <= 1'b1; state_r <= ST_DIV_Y0;
          end
        end
        ST_DIV_Y0: begin
          if (div_done) begin
            qy_r <= 26'(div_quo); remy_r <= div_rem;
            div_start_r <= 1'b1; state_r <= ST_DIV_YS;
          end
        end
        ST_DIV_YS: begin
          if (div_done) begin
            qsy_r <= 26'(div_quo); rsy_r <= div_rem;
            state_r <= ST_ROW_START;
          end
        end
        ST_ROW_START: begin
          ry_r    <= 13'(sy_r[11:0]) + 13'(capy);
          x_r     <= left_r;
          qx_r    <= qx0_r;
          remx_r  <= rx0_r;
          state_r <= ST_ROW_MUL;
        end
        ST_ROW_MUL: begin
          rbs_r   <= 25'(ry_r * iw_r);
          rbc_r   <= 24'(y_r * pitch_r);
          state_r <= ST_PIX_RD;
        end
        ST_PIX_RD: begin
          skip_r    <= (cidx >= CANVAS_LIMIT) || (sidx >= IMAGE_LIMIT);
          cw_addr_r <= cidx[CANVAS_AW-1:0];
          state_r   <= ST_PIX_MUL;
        end
        ST_PIX_MUL: begin
          state_r <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          if (x_r + 12'd1 == right_r) begin
            if (y_r + 12'd1 == bottom_r) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              y_r     <= y_r + 12'd1;
              qy_r    <= qy_r + qsy_r + 26'(remy_wrap);
              remy_r  <= remy_wrap ? 12'(remy_sum - 13'(dh_r)) : remy_sum[11:0];
              state_r <= ST_ROW_START;
            end
          end else begin
            x_r     <= x_r + 12'd1;
            qx_r    <= qx_r + qsx_r + 26'(remx_wrap);
            remx_r  <= remx_wrap ? 12'(remx_sum - 13'(dw_r)) : remx_sum[11:0];
            state_r <= ST_PIX_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire
